// ===== rtl/wbob_pkg.sv =====
`timescale 1ns / 1ps

package wbob_pkg;

    // Table size and derived index width
    localparam int BONE_COUNT = 256;
    localparam int BONE_AW    = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

    // Field widths
    localparam int BONE_W   = 8;
    localparam int VAL_W    = 32;   // Q16.16 offsets, poses and results
    localparam int WEIGHT_W = 18;   // signed Q2.16
    localparam int BLEND_W  = 17;   // unsigned Q1.16
    localparam int FRAC_W   = 16;

    // Internal arithmetic widths
    localparam int PROD_W = VAL_W + WEIGHT_W;   // full product of a lane multiplier
    localparam int RND_W  = PROD_W - FRAC_W;    // product after the Q16 shift
    localparam int SUM_W  = RND_W + 1;          // accumulator plus rounded term

    // Configuration port
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int CFG_IDX_MSB   = 2;
    localparam logic CFG_IDX_BLEND = 1'b0;
    localparam logic [BLEND_W-1:0] BLEND_RESET = BLEND_W'(65536);

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_TERM  = 2'd2
    } t_func;

    // Control bundle from the sequencer to each axis lane
    typedef struct packed {
        logic               en;     // pipeline advance
        logic               wr;     // stage 2: set item writes the table
        logic               rd;     // stage 2: term item reads the table
        logic [BONE_AW-1:0] addr;   // stage 2: table index
        logic               hit;    // stage 3: bone holds a valid offset
        logic [WEIGHT_W-1:0] weight; // stage 3: term weight
        logic               upd;    // stage 4: term updates the accumulator
        logic               clr;    // stage 4: term closes the vertex
    } t_lane_ctrl;

    // Per-lane accumulation result at stage 4
    typedef struct packed {
        logic [VAL_W-1:0] sum;
        logic             sat;
    } t_lane_res;

    // Control bundle to the merge stage
    typedef struct packed {
        logic en;
        logic upd;
        logic last;
    } t_merge_ctrl;

endpackage

// ===== rtl/weighted_bone_offset_blend.sv =====
`timescale 1ns / 1ps

// Translation-only skinning blend. Set, clear and term items stream in at one
// item per clock; a vertex result is loaded into the output register when its
// closing term reaches stage 4. Three axis lanes each own a 256-entry offset
// table (one write-or-read port) and a 32x18 multiply-accumulate; all table
// and valid-bit updates happen in stage 2, so a term always sees every
// earlier set and clear. The input stalls only when a closing term reaches
// stage 4 while the output register still holds an untaken result. No
// clearing pass is needed after reset: unwritten bones read as zero through
// per-bone valid bits. blend is a Q1.16 register at byte address 0.
module weighted_bone_offset_blend
    import wbob_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_func,
    input  logic [BONE_W-1:0]     i_bone,
    input  logic [VAL_W-1:0]      i_pose_x,
    input  logic [VAL_W-1:0]      i_pose_y,
    input  logic [VAL_W-1:0]      i_pose_z,
    input  logic [WEIGHT_W-1:0]   i_weight,
    input  logic                  i_last,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [VAL_W-1:0]      o_vert_x,
    output logic [VAL_W-1:0]      o_vert_y,
    output logic [VAL_W-1:0]      o_vert_z,
    output logic                  o_saturated
);

    logic [BLEND_W-1:0]    r_blend;
    logic                  cfg_wr;
    logic                  en;
    logic                  accept;
    logic                  merge_busy;
    logic [31:0]           bone_wide;
    logic                  bone_ok;
    logic [BONE_AW-1:0]    bone_addr;

    // Stage 1
    logic                  r_set1, r_clr1, r_term1, r_last1, r_ok1;
    logic [BONE_AW-1:0]    r_addr1;
    logic [WEIGHT_W-1:0]   r_w1;
    // Stage 2
    logic                  r_set2, r_clr2, r_term2, r_last2, r_ok2;
    logic [BONE_AW-1:0]    r_addr2;
    logic [WEIGHT_W-1:0]   r_w2;
    // Stage 3
    logic                  r_term3, r_last3, r_hit3;
    logic [WEIGHT_W-1:0]   r_w3;
    // Stage 4
    logic                  r_term4, r_last4;

    logic [BONE_COUNT-1:0] r_bone_set;

    t_lane_ctrl            lane_ctrl;
    t_merge_ctrl           merge_ctrl;
    t_lane_res             res_x, res_y, res_z;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= BLEND_RESET;
        end else if (cfg_wr && paddr[CFG_IDX_MSB] == CFG_IDX_BLEND) begin
            r_blend <= pwdata[BLEND_W-1:0];
        end
    end

    assign prdata = (paddr[CFG_IDX_MSB] == CFG_IDX_BLEND) ? APB_DW'(r_blend) : '0;

    // Pipeline advance: hold only when a result cannot leave stage 4
    assign en         = !(merge_busy && r_term4 && r_last4);
    assign o_in_stall = !en;
    assign accept     = i_in_valid & en;

    // Bone index range check and table address
    assign bone_wide = 32'(i_bone);
    assign bone_ok   = bone_wide < 32'(BONE_COUNT);
    assign bone_addr = bone_wide[BONE_AW-1:0];

    // Control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set1  <= 1'b0;
            r_clr1  <= 1'b0;
            r_term1 <= 1'b0;
            r_set2  <= 1'b0;
            r_clr2  <= 1'b0;
            r_term2 <= 1'b0;
            r_term3 <= 1'b0;
            r_hit3  <= 1'b0;
            r_term4 <= 1'b0;
            r_last4 <= 1'b0;
        end else if (en) begin
            r_set1  <= accept && (i_func == FUNC_SET);
            r_clr1  <= accept && (i_func == FUNC_CLEAR);
            r_term1 <= accept && (i_func == FUNC_TERM);
            r_set2  <= r_set1;
            r_clr2  <= r_clr1;
            r_term2 <= r_term1;
            r_term3 <= r_term2;
            r_hit3  <= r_term2 && r_ok2 && r_bone_set[r_addr2];
            r_term4 <= r_term3;
            r_last4 <= r_last3;
        end
    end

    // Payload side of the control pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last1 <= i_last;
            r_ok1   <= bone_ok;
            r_addr1 <= bone_addr;
            r_w1    <= i_weight;
            r_last2 <= r_last1;
            r_ok2   <= r_ok1;
            r_addr2 <= r_addr1;
            r_w2    <= r_w1;
            r_last3 <= r_last2;
            r_w3    <= r_w2;
        end
    end

    // Bone valid bits, updated in stage 2 in item order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_set <= '0;
        end else if (en) begin
            if (r_clr2) begin
                r_bone_set <= '0;
            end else if (r_set2 && r_ok2) begin
                r_bone_set[r_addr2] <= 1'b1;
            end
        end
    end

    // Lane and merge control bundles
    always_comb begin
        lane_ctrl.en     = en;
        lane_ctrl.wr     = r_set2 & r_ok2;
        lane_ctrl.rd     = r_term2;
        lane_ctrl.addr   = r_addr2;
        lane_ctrl.hit    = r_hit3;
        lane_ctrl.weight = r_w3;
        lane_ctrl.upd    = r_term4;
        lane_ctrl.clr    = r_last4;
        merge_ctrl.en    = en;
        merge_ctrl.upd   = r_term4;
        merge_ctrl.last  = r_last4;
    end

    wbob_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lane_ctrl),
        .i_blend (r_blend),
        .i_pose  (i_pose_x),
        .o_res   (res_x)
    );

    wbob_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lane_ctrl),
        .i_blend (r_blend),
        .i_pose  (i_pose_y),
        .o_res   (res_y)
    );

    wbob_lane u_lane_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lane_ctrl),
        .i_blend (r_blend),
        .i_pose  (i_pose_z),
        .o_res   (res_z)
    );

    wbob_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (merge_ctrl),
        .i_res_x     (res_x),
        .i_res_y     (res_y),
        .i_res_z     (res_z),
        .i_out_stall (i_out_stall),
        .o_busy      (merge_busy),
        .o_out_valid (o_out_valid),
        .o_vert_x    (o_vert_x),
        .o_vert_y    (o_vert_y),
        .o_vert_z    (o_vert_z),
        .o_saturated (o_saturated)
    );

endmodule

// ===== rtl/wbob_ram.sv =====
`timescale 1ns / 1ps

module wbob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wbob_lane.sv =====
`timescale 1ns / 1ps

module wbob_lane
    import wbob_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_ctrl          i_ctrl,
    input  logic [BLEND_W-1:0]  i_blend,
    input  logic [VAL_W-1:0]    i_pose,
    output t_lane_res           o_res
);

    typedef struct packed {
        logic             flag;
        logic [VAL_W-1:0] val;
    } t_sat;

    logic signed [VAL_W-1:0]  r_pose1;
    logic signed [PROD_W-1:0] r_sprod2;
    logic signed [PROD_W-1:0] n_sprod2;
    logic signed [RND_W-1:0]  set_rnd;
    t_sat                     set_sat;
    logic [VAL_W-1:0]         ram_rdata;
    logic signed [VAL_W-1:0]  offset3;
    logic signed [PROD_W-1:0] r_tprod4;
    logic signed [PROD_W-1:0] n_tprod4;
    logic signed [RND_W-1:0]  term_rnd;
    logic signed [SUM_W-1:0]  acc_sum;
    t_sat                     acc_sat;
    logic signed [VAL_W-1:0]  r_acc;

    // Round a Q.32 product to Q.16: add half an LSB, floor shift
    function automatic logic signed [RND_W-1:0] round16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(1 << (FRAC_W - 1));
        return t[PROD_W-1:FRAC_W];
    endfunction

    // Clamp to signed 32 bits; flag when the top bits disagree
    function automatic t_sat sat32(input logic signed [SUM_W-1:0] v);
        t_sat r;
        if ((&v[SUM_W-1:VAL_W-1]) || !(|v[SUM_W-1:VAL_W-1])) begin
            r.flag = 1'b0;
            r.val  = v[VAL_W-1:0];
        end else begin
            r.flag = 1'b1;
            r.val  = v[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Stage 1: scale the pose by the blend factor
    assign n_sprod2 = PROD_W'(r_pose1) * PROD_W'($signed({1'b0, i_blend}));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_pose1  <= i_pose;
            r_sprod2 <= n_sprod2;
        end
    end

    // Stage 2: round and clamp the scaled pose, write or read the table
    assign set_rnd = round16(r_sprod2);
    assign set_sat = sat32(SUM_W'(set_rnd));

    wbob_ram #(
        .WIDTH (VAL_W),
        .DEPTH (BONE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.en & i_ctrl.wr),
        .i_waddr (i_ctrl.addr),
        .i_wdata (set_sat.val),
        .i_re    (i_ctrl.en & i_ctrl.rd),
        .i_raddr (i_ctrl.addr),
        .o_rdata (ram_rdata)
    );

    // Stage 3: weight the offset, unset bones read as zero
    assign offset3  = i_ctrl.hit ? ram_rdata : '0;
    assign n_tprod4 = PROD_W'(offset3) * PROD_W'($signed(i_ctrl.weight));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_tprod4 <= n_tprod4;
        end
    end

    // Stage 4: accumulate with saturation
    assign term_rnd = round16(r_tprod4);
    assign acc_sum  = SUM_W'(r_acc) + SUM_W'(term_rnd);
    assign acc_sat  = sat32(acc_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.en && i_ctrl.upd) begin
            r_acc <= i_ctrl.clr ? '0 : acc_sat.val;
        end
    end

    assign o_res.sum = acc_sat.val;
    assign o_res.sat = acc_sat.flag;

endmodule

// ===== rtl/wbob_merge.sv =====
`timescale 1ns / 1ps

module wbob_merge
    import wbob_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_merge_ctrl       i_ctrl,
    input  t_lane_res         i_res_x,
    input  t_lane_res         i_res_y,
    input  t_lane_res         i_res_z,
    input  logic              i_out_stall,
    output logic              o_busy,
    output logic              o_out_valid,
    output logic [VAL_W-1:0]  o_vert_x,
    output logic [VAL_W-1:0]  o_vert_y,
    output logic [VAL_W-1:0]  o_vert_z,
    output logic              o_saturated
);

    logic             r_acc_sat;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_vert_x;
    logic [VAL_W-1:0] r_vert_y;
    logic [VAL_W-1:0] r_vert_z;
    logic             r_sat;
    logic             any_sat;
    logic             fire;

    assign any_sat = r_acc_sat | i_res_x.sat | i_res_y.sat | i_res_z.sat;
    assign fire    = i_ctrl.en & i_ctrl.upd & i_ctrl.last;

    // Sticky saturation flag across the terms of one vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_sat <= 1'b0;
        end else if (i_ctrl.en && i_ctrl.upd) begin
            r_acc_sat <= i_ctrl.last ? 1'b0 : any_sat;
        end
    end

    // Output register: load on a closing term, drop once the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_vert_x <= i_res_x.sum;
            r_vert_y <= i_res_y.sum;
            r_vert_z <= i_res_z.sum;
            r_sat    <= any_sat;
        end
    end

    assign o_busy      = r_out_valid & i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_vert_x    = r_vert_x;
    assign o_vert_y    = r_vert_y;
    assign o_vert_z    = r_vert_z;
    assign o_saturated = r_sat;

endmodule
